@@ rtl/vibi_pkg.sv @@
// Package: shared constants, configuration and plan types for the vertex index byte inserter.
`default_nettype none
package vibi_pkg;

   // Output list alignment in bytes (power of two)
   localparam int unsigned ALIGN_BYTES = 32;
   localparam int unsigned ALIGN_W     = $clog2(ALIGN_BYTES);
   // Bytes one item may produce: up to two list bytes plus padding
   localparam int unsigned TOTAL_W     = $clog2(ALIGN_BYTES + 2);

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_VERTEX_STRIDE    = 3'd0,
      CSR_INSERT_OFFSET    = 3'd1,
      CSR_INDEX_BASE       = 3'd2,
      CSR_FAN_OPCODE       = 3'd3,
      CSR_STRIP_OPCODE     = 3'd4,
      CSR_COUNT_BIG_ENDIAN = 3'd5
   } csr_addr_type;

   typedef struct packed {
      logic [7:0] vertex_stride;
      logic [7:0] insert_offset;
      logic [7:0] index_base;
      logic [7:0] fan_opcode;
      logic [7:0] strip_opcode;
      logic       count_big_endian;
   } cfg_type;

   // Output bytes caused by one item
   typedef struct packed {
      logic [7:0]         byte0;
      logic               ins0;
      logic [7:0]         byte1;
      logic               ins1;
      logic [1:0]         n_data;   // list bytes before padding
      logic [TOTAL_W-1:0] total;    // list bytes plus padding
      logic               list_end; // final byte carries tlast
   } plan_type;

endpackage
`default_nettype wire

@@ rtl/vibi_csr.sv @@
// Configuration registers of the vertex index byte inserter.
`default_nettype none
module vibi_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [vibi_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [vibi_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output vibi_pkg::cfg_type                     cfg
);

   vibi_pkg::cfg_type cfg_ff;
   vibi_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (vibi_pkg::csr_addr_type'(csr_addr))
            vibi_pkg::CSR_VERTEX_STRIDE:    cfg_in.vertex_stride    = csr_wdata;
            vibi_pkg::CSR_INSERT_OFFSET:    cfg_in.insert_offset    = csr_wdata;
            vibi_pkg::CSR_INDEX_BASE:       cfg_in.index_base       = csr_wdata;
            vibi_pkg::CSR_FAN_OPCODE:       cfg_in.fan_opcode       = csr_wdata;
            vibi_pkg::CSR_STRIP_OPCODE:     cfg_in.strip_opcode     = csr_wdata;
            vibi_pkg::CSR_COUNT_BIG_ENDIAN: cfg_in.count_big_endian = csr_wdata[0];
            default: ; // unused indexes ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_stride    <= 8'd1;
         cfg_ff.insert_offset    <= 8'd0;
         cfg_ff.index_base       <= 8'd0;
         cfg_ff.fan_opcode       <= 8'd160;
         cfg_ff.strip_opcode     <= 8'd152;
         cfg_ff.count_big_endian <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ rtl/vibi_parser.sv @@
// Display list parser: tracks command/count/vertex phase and builds the plan for each item.
`default_nettype none
module vibi_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire vibi_pkg::cfg_type cfg,
   input  wire logic              in_accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output vibi_pkg::plan_type     plan
);

   typedef enum logic [2:0] {
      PH_CMD  = 3'd0,
      PH_CNT0 = 3'd1,
      PH_CNT1 = 3'd2,
      PH_VTX  = 3'd3,
      PH_DROP = 3'd4
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [7:0]                    cnt_first_ff, cnt_first_in;
   logic [15:0]                   vleft_ff, vleft_in;
   logic [7:0]                    biv_ff, biv_in;
   logic [7:0]                    vfb_ff, vfb_in;
   logic [vibi_pkg::ALIGN_W-1:0]  mod_ff, mod_in;

   logic [8:0]                    eff_stride;
   logic [8:0]                    eff_offset;
   logic [8:0]                    pos_next;
   logic [15:0]                   count;
   logic [15:0]                   vleft_dec;
   logic [7:0]                    vfb_cur;
   logic [7:0]                    idx_byte;
   logic                          ins_pre;
   logic                          ins_post;
   logic [1:0]                    n_data;
   logic [vibi_pkg::ALIGN_W-1:0]  mod_after;
   logic [vibi_pkg::ALIGN_W-1:0]  pad;

   always_comb begin
      eff_stride = (cfg.vertex_stride == 8'd0) ? 9'd256 : {1'b0, cfg.vertex_stride};
      eff_offset = ({1'b0, cfg.insert_offset} < eff_stride) ? {1'b0, cfg.insert_offset}
                                                             : eff_stride;
      vfb_cur    = (biv_ff == 8'd0) ? in_byte : vfb_ff;
      idx_byte   = cfg.index_base + vfb_cur;
      ins_pre    = ({1'b0, biv_ff} == eff_offset);
      ins_post   = (eff_offset == eff_stride) && ({1'b0, biv_ff} == eff_stride - 9'd1);
      pos_next   = {1'b0, biv_ff} + 9'd1;
      vleft_dec  = vleft_ff - 16'd1;
      count      = cfg.count_big_endian ? {cnt_first_ff, in_byte} : {in_byte, cnt_first_ff};

      phase_in     = phase_ff;
      cnt_first_in = cnt_first_ff;
      vleft_in     = vleft_ff;
      biv_in       = biv_ff;
      vfb_in       = vfb_ff;

      plan.byte0 = in_byte;
      plan.ins0  = 1'b0;
      plan.byte1 = idx_byte;
      plan.ins1  = 1'b1;
      n_data     = 2'd1;

      unique case (phase_ff)
         PH_CMD: begin
            phase_in = (in_byte == cfg.fan_opcode || in_byte == cfg.strip_opcode)
                       ? PH_CNT0 : PH_DROP;
         end
         PH_CNT0: begin
            cnt_first_in = in_byte;
            phase_in     = PH_CNT1;
         end
         PH_CNT1: begin
            vleft_in = count;
            biv_in   = 8'd0;
            phase_in = (count != 16'd0) ? PH_VTX : PH_CMD;
         end
         PH_VTX: begin
            vfb_in = vfb_cur;
            if (ins_pre) begin
               plan.byte0 = idx_byte;
               plan.ins0  = 1'b1;
               plan.byte1 = in_byte;
               plan.ins1  = 1'b0;
            end
            n_data = (ins_pre || ins_post) ? 2'd2 : 2'd1;
            if (pos_next >= eff_stride) begin
               biv_in   = 8'd0;
               vleft_in = vleft_dec;
               if (vleft_dec == 16'd0) begin
                  phase_in = PH_CMD;
               end
            end else begin
               biv_in = pos_next[7:0];
            end
         end
         default: begin
            phase_in = PH_DROP;
            n_data   = 2'd0;
         end
      endcase

      mod_after = mod_ff + vibi_pkg::ALIGN_W'(n_data);
      pad       = in_last ? (vibi_pkg::ALIGN_W'(0) - mod_after) : '0;
      mod_in    = in_last ? '0 : mod_after;

      plan.n_data   = n_data;
      plan.total    = vibi_pkg::TOTAL_W'(n_data) + vibi_pkg::TOTAL_W'(pad);
      plan.list_end = in_last;

      if (in_last) begin
         phase_in     = PH_CMD;
         cnt_first_in = '0;
         vleft_in     = '0;
         biv_in       = '0;
         vfb_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CMD;
         cnt_first_ff <= '0;
         vleft_ff     <= '0;
         biv_ff       <= '0;
         vfb_ff       <= '0;
         mod_ff       <= '0;
      end else if (in_accept) begin
         phase_ff     <= phase_in;
         cnt_first_ff <= cnt_first_in;
         vleft_ff     <= vleft_in;
         biv_ff       <= biv_in;
         vfb_ff       <= vfb_in;
         mod_ff       <= mod_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/vibi_emitter.sv @@
// Plan register and output register: sends the bytes of one plan, one per cycle while rsp_tready does not stall.
`default_nettype none
module vibi_emitter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               plan_load,
   input  wire vibi_pkg::plan_type plan,
   output logic                    plan_free,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   vibi_pkg::plan_type           plan_ff, plan_in;
   logic                         plan_valid_ff, plan_valid_in;
   logic [vibi_pkg::TOTAL_W-1:0] idx_ff, idx_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]                   rsp_tdata_ff, rsp_tdata_in;
   logic                         rsp_tuser_ff, rsp_tuser_in;
   logic                         rsp_tlast_ff, rsp_tlast_in;

   logic                         out_load;
   logic                         plan_done;
   logic                         at_end;

   always_comb begin
      out_load  = plan_valid_ff && (!rsp_tvalid_ff || rsp_tready);
      at_end    = (idx_ff == plan_ff.total - vibi_pkg::TOTAL_W'(1));
      plan_done = out_load && at_end;
      plan_free = !plan_valid_ff || plan_done;

      plan_in       = plan_ff;
      plan_valid_in = plan_valid_ff;
      idx_in        = idx_ff;
      if (plan_load) begin
         plan_in       = plan;
         plan_valid_in = 1'b1;
         idx_in        = '0;
      end else if (plan_done) begin
         plan_valid_in = 1'b0;
      end else if (out_load) begin
         idx_in = idx_ff + vibi_pkg::TOTAL_W'(1);
      end

      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         if (idx_ff == '0 && plan_ff.n_data != 2'd0) begin
            rsp_tdata_in = plan_ff.byte0;
            rsp_tuser_in = plan_ff.ins0;
         end else if (idx_ff == vibi_pkg::TOTAL_W'(1) && plan_ff.n_data == 2'd2) begin
            rsp_tdata_in = plan_ff.byte1;
            rsp_tuser_in = plan_ff.ins1;
         end else begin
            rsp_tdata_in = 8'd0; // padding
            rsp_tuser_in = 1'b0;
         end
         rsp_tlast_in = plan_ff.list_end && at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      plan_ff      <= plan_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      plan_valid_ff |-> (idx_ff < plan_ff.total))
      else $error("plan index beyond plan length");
   a_plan_nonempty: assert property (@(posedge clock) disable iff (reset)
      plan_valid_ff |-> (plan_ff.total != '0))
      else $error("empty plan held");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      plan_load |-> (!plan_valid_ff || plan_done))
      else $error("plan overwritten before fully sent");
   a_last_ends_plan: assert property (@(posedge clock) disable iff (reset)
      (out_load && plan_ff.list_end && at_end) |=> (rsp_tvalid_ff && rsp_tlast_ff))
      else $error("final byte of list lost its tlast");
`endif

endmodule
`default_nettype wire

@@ rtl/vertex_index_byte_inserter_top.sv @@
// Top level of the vertex index byte inserter: display list byte stream rewriter.
// Usage:
//  - req_* carries the source display list, one byte per item; req_tlast marks the
//    final source byte. rsp_* carries the rewritten list one byte per item;
//    rsp_tuser flags an inserted index byte, rsp_tlast the final (padded) byte.
//  - csr_* writes the six configuration registers; write only while idle.
//  - Path: an accepted item's plan is held in the plan register, and its bytes
//    move from there through the output register to rsp_*.
//  - Throughput: one output byte per cycle while rsp_tready is high, set by the
//    single output register. Command, count and plain vertex bytes go at one
//    item per cycle; a vertex byte that gains an inserted index byte emits two
//    bytes, and a list end pads the output to a 32-byte boundary. Dropped bytes
//    after a non-primitive command emit nothing.
//  - The next item is taken while the previous item's last byte waits in the
//    output register, so the source sees no bubble in the copy phases.
//  - rsp_tready low stalls the output register; the held plan then blocks
//    req_tready until its bytes drain. Nothing is lost or reordered.
//  - Reset (synchronous) restores register defaults, empties the pipeline and
//    returns the parser to expecting a command byte.
`default_nettype none
module vertex_index_byte_inserter_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // source list
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // [7:0] in_byte
   input  wire logic                            req_tlast,  // list_end
   // rewritten list
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,  // [7:0] out_byte
   output logic                                 rsp_tuser,  // out_inserted
   output logic                                 rsp_tlast,  // out_last
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [vibi_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [vibi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   vibi_pkg::cfg_type  cfg;
   vibi_pkg::plan_type plan;
   logic               plan_free;
   logic               in_accept;
   logic               plan_load;

   assign req_tready = plan_free;
   assign in_accept  = req_tvalid && req_tready;
   // items that emit nothing (dropped bytes, aligned end) only update the parser
   assign plan_load  = in_accept && (plan.total != '0);

   vibi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vibi_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_accept (in_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .plan      (plan)
   );

   vibi_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .plan_load  (plan_load),
      .plan       (plan),
      .plan_free  (plan_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ tb/vertex_index_byte_inserter_top_test.sv @@
// Self-checking testbench for the display list rewriter: random lists, random stalls, scoreboard.
`timescale 1ns / 1ps
module vertex_index_byte_inserter_top_test;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 7;
   // Longest list end pads 31 bytes plus two pipeline stages; allow margin
   localparam int TAIL_CYCLES  = 40;
   // Cycles with no item moving on either side before the run is abandoned
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 12;
   localparam int REPORT_MAX   = 10;
   // Register indexes the block does not decode
   localparam logic [vibi_pkg::CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [vibi_pkg::CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;
   // A command byte used where a plain (non-primitive) command is wanted
   localparam bit [7:0] PLAIN_CMD = 8'h00;

   // Where the list parser stands
   typedef enum {
      EXPECT_CMD,
      EXPECT_COUNT_A,
      EXPECT_COUNT_B,
      IN_VERTEX,
      DROPPING
   } parse_type;

   typedef struct {
      bit [7:0] data;
      bit       inserted;
      bit       last;
   } list_byte_type;

   // Predicts the rewritten list from the source bytes the block accepts
   class list_rewrite_scoreboard;
      bit [7:0]   stride     = 8'd1;
      bit [7:0]   offset     = 8'd0;
      bit [7:0]   base       = 8'd0;
      bit [7:0]   fan_op     = 8'd160;
      bit [7:0]   strip_op   = 8'd152;
      bit         big_endian = 1'b1;

      parse_type  phase      = EXPECT_CMD;
      bit [7:0]   count_first;
      bit [15:0]  verts_left;
      int         pos_in_vertex;
      bit [7:0]   first_byte;
      int         out_mod;

      list_byte_type expected_q[$];
      int         mismatches;
      int         checked_bytes;
      int         inserted_bytes;
      int         list_ends;

      function void set_register(logic [vibi_pkg::CSR_ADDR_W-1:0] addr, bit [7:0] value);
         case (addr)
            vibi_pkg::CSR_VERTEX_STRIDE:    stride     = value;
            vibi_pkg::CSR_INSERT_OFFSET:    offset     = value;
            vibi_pkg::CSR_INDEX_BASE:       base       = value;
            vibi_pkg::CSR_FAN_OPCODE:       fan_op     = value;
            vibi_pkg::CSR_STRIP_OPCODE:     strip_op   = value;
            vibi_pkg::CSR_COUNT_BIG_ENDIAN: big_endian = value[0];
            default: ;
         endcase
      endfunction

      function void push_byte(bit [7:0] data, bit inserted);
         list_byte_type item;
         item.data     = data;
         item.inserted = inserted;
         item.last     = 1'b0;
         expected_q.push_back(item);
         out_mod = (out_mod + 1) % int'(vibi_pkg::ALIGN_BYTES);
      endfunction

      function void note_source_byte(bit [7:0] b, bit list_end);
         int       n_out;
         int       eff_stride;
         int       eff_off;
         bit [15:0] count;
         bit [7:0] index_byte;
         n_out = expected_q.size();
         case (phase)
            EXPECT_CMD: begin
               push_byte(b, 1'b0);
               phase = (b == fan_op || b == strip_op) ? EXPECT_COUNT_A : DROPPING;
            end
            EXPECT_COUNT_A: begin
               push_byte(b, 1'b0);
               count_first = b;
               phase = EXPECT_COUNT_B;
            end
            EXPECT_COUNT_B: begin
               count = big_endian ? {count_first, b} : {b, count_first};
               push_byte(b, 1'b0);
               verts_left    = count;
               pos_in_vertex = 0;
               phase = (count != 0) ? IN_VERTEX : EXPECT_CMD;
            end
            IN_VERTEX: begin
               // stride zero reads as 256; an offset past the stride inserts at the end
               eff_stride = (stride == 0) ? 256 : int'(stride);
               eff_off    = (int'(offset) < eff_stride) ? int'(offset) : eff_stride;
               if (pos_in_vertex == 0) first_byte = b;
               index_byte = base + first_byte;
               if (pos_in_vertex == eff_off) push_byte(index_byte, 1'b1);
               push_byte(b, 1'b0);
               if (eff_off == eff_stride && pos_in_vertex == eff_stride - 1)
                  push_byte(index_byte, 1'b1);
               pos_in_vertex++;
               if (pos_in_vertex >= eff_stride) begin
                  pos_in_vertex = 0;
                  verts_left--;
                  if (verts_left == 0) phase = EXPECT_CMD;
               end
            end
            default: phase = DROPPING;
         endcase
         if (list_end) begin
            while (out_mod != 0) push_byte(8'h00, 1'b0);
            // an aligned list end that emits nothing marks no byte
            if (expected_q.size() > n_out) expected_q[expected_q.size() - 1].last = 1'b1;
            phase         = EXPECT_CMD;
            count_first   = 8'h00;
            verts_left    = 16'h0000;
            pos_in_vertex = 0;
            first_byte    = 8'h00;
            out_mod       = 0;
         end
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= REPORT_MAX) $display("ERROR: %s", msg);
      endfunction

      function void check_output(logic [7:0] data, logic inserted, logic last);
         list_byte_type want;
         if (expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected output byte %02h inserted %b last %b",
                                    data, inserted, last));
            return;
         end
         want = expected_q.pop_front();
         checked_bytes++;
         if (want.inserted) inserted_bytes++;
         if (want.last) list_ends++;
         if (data !== want.data || inserted !== want.inserted || last !== want.last)
            note_mismatch($sformatf(
               "output byte %0d: expected %02h inserted %b last %b, got %02h inserted %b last %b",
               checked_bytes, want.data, want.inserted, want.last, data, inserted, last));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = 8'h00;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [7:0]                      rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_we     = 1'b0;
   logic [vibi_pkg::CSR_ADDR_W-1:0] csr_addr   = vibi_pkg::CSR_VERTEX_STRIDE;
   logic [vibi_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   list_rewrite_scoreboard sb = new;

   bit       calm;          // no idling on either side while set
   bit [7:0] list_q[$];     // source list being built
   int       rsp_hold;      // cycles the receiver still stalls
   int       quiet_cycles;  // cycles since any item moved
   int       source_bytes;
   int       lists_sent;
   int       settings_used;

   vertex_index_byte_inserter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_byte
      .req_tlast  (req_tlast),   // list_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte
      .rsp_tuser  (rsp_tuser),   // out_inserted
      .rsp_tlast  (rsp_tlast),   // out_last
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Receiver: check each item taken, then draw a stall before the next one
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_output(rsp_tdata, rsp_tuser, rsp_tlast);
            rsp_hold = calm ? 0 : $urandom_range(0, 5);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Watchdog: give up once nothing has moved for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // One source byte: optional gap, then hold it until taken.
   // Leaves req_tvalid high so the next byte can follow without a bubble.
   task automatic send_byte(input bit [7:0] value, input bit end_of_list);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= end_of_list;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_source_byte(value, end_of_list);
      source_bytes++;
   endtask

   // Source holds off until every expected byte is out
   task automatic drain_pending();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Block idle: drained, then time for a silent list end to pass through
   task automatic settle();
      drain_pending();
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_list();
      foreach (list_q[i]) begin
         if (!calm && $urandom_range(0, 49) == 0) drain_pending();
         send_byte(list_q[i], i == list_q.size() - 1);
      end
      lists_sent++;
   endtask

   task automatic csr_write(input logic [vibi_pkg::CSR_ADDR_W-1:0] addr,
                            input bit [7:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(addr, value);
   endtask

   // Writes all six registers, plus the undecoded indexes which must change nothing
   task automatic set_config(input bit [7:0] stride, input bit [7:0] offset,
                             input bit [7:0] base, input bit [7:0] fan,
                             input bit [7:0] strip, input bit big_endian);
      csr_write(CSR_SPARE_LO, 8'($urandom_range(0, 255)));
      csr_write(vibi_pkg::CSR_VERTEX_STRIDE, stride);
      csr_write(vibi_pkg::CSR_INSERT_OFFSET, offset);
      csr_write(vibi_pkg::CSR_INDEX_BASE, base);
      csr_write(vibi_pkg::CSR_FAN_OPCODE, fan);
      csr_write(vibi_pkg::CSR_STRIP_OPCODE, strip);
      // upper bits of the flag write are noise
      csr_write(vibi_pkg::CSR_COUNT_BIG_ENDIAN, {7'($urandom_range(0, 127)), big_endian});
      csr_write(CSR_SPARE_HI, 8'($urandom_range(0, 255)));
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function automatic void push_count(input bit [15:0] count);
      if (sb.big_endian) begin
         list_q.push_back(count[15:8]);
         list_q.push_back(count[7:0]);
      end else begin
         list_q.push_back(count[7:0]);
         list_q.push_back(count[15:8]);
      end
   endfunction

   function automatic bit [7:0] plain_command();
      bit [7:0] op;
      do op = 8'($urandom_range(0, 255)); while (op == sb.fan_op || op == sb.strip_op);
      return op;
   endfunction

   // Well-formed list with random content: primitives, then an end command,
   // a truncation or nothing. Huge counts are always cut short.
   task automatic send_random_list(input int max_count);
      int       n_prims;
      int       count;
      int       cut;
      int       eff_stride;
      bit       truncated;
      list_q.delete();
      truncated  = 1'b0;
      eff_stride = (sb.stride == 0) ? 256 : int'(sb.stride);
      n_prims    = $urandom_range(1, 2);
      for (int p = 0; p < n_prims && !truncated; p++) begin
         list_q.push_back($urandom_range(0, 1) ? sb.fan_op : sb.strip_op);
         if ($urandom_range(0, 9) == 0) begin
            count = $urandom_range(0, 1) ? 65535 : $urandom_range(256, 65534);
            push_count(16'(count));
            repeat ($urandom_range(1, 3 * eff_stride)) list_q.push_back(8'($urandom_range(0, 255)));
            truncated = 1'b1;
         end else begin
            count = $urandom_range(0, max_count);
            push_count(16'(count));
            repeat (count * eff_stride) list_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      if (!truncated) begin
         case ($urandom_range(0, 3))
            0: ;
            1: begin
               list_q.push_back(plain_command());
               repeat ($urandom_range(1, 3)) list_q.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
               cut = $urandom_range(1, 3);
               while (cut > 0 && list_q.size() > 1) begin
                  void'(list_q.pop_back());
                  cut--;
               end
            end
            default: list_q.push_back(plain_command());
         endcase
      end
      send_list();
   endtask

   // Short run of arbitrary bytes
   task automatic send_noise_list();
      list_q.delete();
      repeat ($urandom_range(1, 6)) list_q.push_back(8'($urandom_range(0, 255)));
      send_list();
   endtask

   task automatic random_lists(input int max_count);
      int first_byte_no;
      first_byte_no = source_bytes;
      while (source_bytes - first_byte_no < PHASE_ITEMS) begin
         if ($urandom_range(0, 4) == 0) send_noise_list();
         else send_random_list(max_count);
      end
   endtask

   initial begin
      bit [7:0] s;
      bit [7:0] o;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: fan with extreme vertex bytes, zero-count strip,
      // plain command, then dropped bytes up to the list end
      list_q = {sb.fan_op, 8'h00, 8'h02, 8'h00, 8'hFF, sb.strip_op, 8'h00, 8'h00,
                PLAIN_CMD, 8'hFF, 8'h5A};
      send_list();
      // list end inside the count
      list_q = {sb.strip_op, 8'hFF};
      send_list();
      // exactly 32 bytes out, then a dropped byte ends the list: nothing to mark
      list_q = {sb.fan_op, 8'h00, 8'h0E};
      repeat (14) list_q.push_back(8'($urandom_range(0, 255)));
      list_q.push_back(8'h11);
      list_q.push_back(8'h22);
      send_list();
      settle();

      // Smallest stride, offset far beyond it, little-endian counts
      set_config(8'd1, 8'd255, 8'd255, 8'h00, 8'hFF, 1'b0);
      random_lists(6);
      settle();

      // Wide vertex with the index after its last byte, then a huge count cut short
      calm = 1'b1;
      set_config(8'd48, 8'd255, 8'd1, 8'hFF, 8'h00, 1'b1);
      list_q = {sb.fan_op, 8'h00, 8'h01};
      repeat (48) list_q.push_back(8'($urandom_range(0, 255)));
      list_q.push_back(sb.strip_op);
      list_q.push_back(8'hFF);
      list_q.push_back(8'hFF);
      repeat (5) list_q.push_back(8'($urandom_range(0, 255)));
      send_list();
      calm = 1'b0;
      settle();

      // Offset equal to stride, fan and strip share one opcode
      set_config(8'd3, 8'd3, 8'h80, 8'h42, 8'h42, 1'b0);
      random_lists(4);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         s = (ph == 5) ? 8'($urandom_range(9, 20)) : 8'($urandom_range(1, 6));
         o = 8'($urandom_range(0, s + 1));
         set_config(s, o, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         calm = (ph % 3 == 1);
         random_lists((s > 4) ? 2 : 5);
         settle();
      end

      $display("Sent %0d source bytes in %0d lists under %0d register settings.",
               source_bytes, lists_sent, settings_used);
      $display("Checked %0d output bytes: %0d inserted index bytes, %0d list ends marked.",
               sb.checked_bytes, sb.inserted_bytes, sb.list_ends);
      if (sb.pending() != 0)
         $display("ERROR: %0d expected output bytes never arrived", sb.pending());
      if (sb.mismatches > REPORT_MAX)
         $display("%0d mismatches in total", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/vibi_pkg.sv
rtl/vibi_csr.sv
rtl/vibi_parser.sv
rtl/vibi_emitter.sv
rtl/vertex_index_byte_inserter_top.sv
tb/vertex_index_byte_inserter_top_test.sv
